// ===== sv/bdxc_pkg.sv =====
package bdxc_pkg;

  // escape codes of the line coding
  localparam logic [7:0] ESC_BYTE = 8'h7d;
  localparam logic [7:0] ESC_FLAG = 8'h5e;
  localparam logic [7:0] ESC_ESC  = 8'h5d;

  // reset value of the restored flag byte
  localparam logic [7:0] FLAG_RESET = 8'h7e;

  // depth of the queue between decode and output
  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BADESC   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // one queue entry: an optional data byte, then an optional status
  typedef struct packed {
    logic       has_data;
    logic [7:0] data;
    logic       has_status;
    status_t    status;
  } entry_t;

  // write side of the queue
  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  // read side of the queue
  typedef struct packed {
    logic   empty;
    logic   full;
    entry_t head;
  } q_rd_t;

endpackage

// ===== sv/bdxc_in_if.sv =====
interface bdxc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_end;

  modport source (output valid, output in_byte, output frame_end, input ready);
  modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

// ===== sv/bdxc_out_if.sv =====
interface bdxc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_status;
  logic [1:0] frame_status;

  modport source (output valid, output out_byte, output is_status, output frame_status,
                  input ready);
  modport sink   (input valid, input out_byte, input is_status, input frame_status,
                  output ready);
endinterface

// ===== sv/byte_destuffer_xor_check_top.sv =====
// Byte destuffer with XOR check: takes one stuffed byte per cycle while the queue is not
// full (frame_end on the last), undoes the 0x7d escapes, holds back the newest decoded
// byte as the check byte, emits the bytes before it and, after the last byte, one status
// item (0 ok, 1 mismatch, 2 bad or trailing escape, 3 empty). Input rate is one byte per
// cycle while the queue has room, set by the escape/hold update in the decode stage; the
// output side sends one item per cycle while out_ch.ready is high, so the last byte of a
// frame, which can yield a data item and the status, is absorbed by the four-entry queue
// between decode and output. Write flag_value (reset 0x7e) only while the block is idle.
module byte_destuffer_xor_check_top (
  input  logic        clk,
  input  logic        rst,
  bdxc_in_if.sink     in_ch,
  bdxc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);

  bdxc_pkg::q_wr_t q_wr;
  bdxc_pkg::q_rd_t q_rd;
  logic            pop;

  bdxc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_rd.full),
    .q_wr     (q_wr)
  );

  bdxc_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (pop),
    .q_rd (q_rd)
  );

  bdxc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_rd   (q_rd),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sv/bdxc_front.sv =====
module bdxc_front (
  input  logic                clk,
  input  logic                rst,
  bdxc_in_if.sink             in_ch,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                q_full,
  output bdxc_pkg::q_wr_t     q_wr
);

  logic [7:0] flag_value;
  logic [7:0] running_xor;
  logic [7:0] held_byte;
  logic       held_valid;
  logic       escape_pending;
  logic       escape_error;

  logic [7:0] running_xor_next;
  logic [7:0] held_byte_next;
  logic       held_valid_next;
  logic       escape_pending_next;
  logic       escape_error_next;

  logic       have;
  logic [7:0] dec;
  logic       emit;
  logic       accept;
  bdxc_pkg::status_t status;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // escape decode
  always_comb begin
    have                = 1'b0;
    dec                 = in_ch.in_byte;
    escape_pending_next = 1'b0;
    escape_error_next   = escape_error;
    if (escape_pending) begin
      if (in_ch.in_byte == bdxc_pkg::ESC_FLAG) begin
        dec  = flag_value;
        have = 1'b1;
      end else if (in_ch.in_byte == bdxc_pkg::ESC_ESC) begin
        dec  = bdxc_pkg::ESC_BYTE;
        have = 1'b1;
      end else begin
        // invalid escape: drop the escape, decode this byte afresh
        escape_error_next = 1'b1;
        if (in_ch.in_byte == bdxc_pkg::ESC_BYTE) begin
          escape_pending_next = 1'b1;
        end else begin
          have = 1'b1;
        end
      end
    end else if (in_ch.in_byte == bdxc_pkg::ESC_BYTE) begin
      escape_pending_next = 1'b1;
    end else begin
      have = 1'b1;
    end
  end

  // hold-back of the newest byte and running check
  always_comb begin
    emit             = have && held_valid;
    running_xor_next = emit ? (running_xor ^ held_byte) : running_xor;
    held_byte_next   = have ? dec : held_byte;
    held_valid_next  = held_valid || have;
  end

  // end-of-frame status, bad escape first
  always_comb begin
    if (escape_error_next || escape_pending_next) begin
      status = bdxc_pkg::ST_BADESC;
    end else if (!held_valid_next) begin
      status = bdxc_pkg::ST_EMPTY;
    end else if (running_xor_next != held_byte_next) begin
      status = bdxc_pkg::ST_MISMATCH;
    end else begin
      status = bdxc_pkg::ST_OK;
    end
  end

  // queue write
  always_comb begin
    q_wr.push             = accept && (emit || in_ch.frame_end);
    q_wr.entry.has_data   = emit;
    q_wr.entry.data       = held_byte;
    q_wr.entry.has_status = in_ch.frame_end;
    q_wr.entry.status     = status;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_value <= bdxc_pkg::FLAG_RESET;
    end else if (cfg_we) begin
      flag_value <= cfg_data;
    end
  end

  // frame state; cleared after the status
  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor    <= '0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      escape_pending <= 1'b0;
      escape_error   <= 1'b0;
    end else if (accept) begin
      if (in_ch.frame_end) begin
        running_xor    <= '0;
        held_byte      <= '0;
        held_valid     <= 1'b0;
        escape_pending <= 1'b0;
        escape_error   <= 1'b0;
      end else begin
        running_xor    <= running_xor_next;
        held_byte      <= held_byte_next;
        held_valid     <= held_valid_next;
        escape_pending <= escape_pending_next;
        escape_error   <= escape_error_next;
      end
    end
  end

endmodule

// ===== sv/bdxc_fifo.sv =====
module bdxc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  bdxc_pkg::q_wr_t q_wr,
  input  logic            pop,
  output bdxc_pkg::q_rd_t q_rd
);

  bdxc_pkg::entry_t mem [bdxc_pkg::QDEPTH];

  logic [bdxc_pkg::PTR_W-1:0] wr_ptr;
  logic [bdxc_pkg::PTR_W-1:0] rd_ptr;
  logic [bdxc_pkg::CNT_W-1:0] count;

  assign q_rd.empty = (count == '0);
  assign q_rd.full  = (count == bdxc_pkg::CNT_W'(bdxc_pkg::QDEPTH));
  assign q_rd.head  = mem[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr] <= q_wr.entry;
    end
  end

  // pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= (wr_ptr == bdxc_pkg::PTR_W'(bdxc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == bdxc_pkg::PTR_W'(bdxc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({q_wr.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/bdxc_back.sv =====
module bdxc_back (
  input  logic            clk,
  input  logic            rst,
  input  bdxc_pkg::q_rd_t q_rd,
  output logic            pop,
  bdxc_out_if.source      out_ch
);

  logic             cur_valid;
  bdxc_pkg::entry_t cur;
  logic             out_accept;
  logic             done;

  assign out_accept = out_ch.valid && out_ch.ready;
  // entry finished when its last item leaves
  assign done       = out_accept && (!cur.has_data || !cur.has_status);
  assign pop        = (!cur_valid || done) && !q_rd.empty;

  // data item first, then status item
  assign out_ch.valid        = cur_valid;
  assign out_ch.out_byte     = cur.has_data ? cur.data : 8'h00;
  assign out_ch.is_status    = !cur.has_data;
  assign out_ch.frame_status = cur.has_data ? bdxc_pkg::ST_OK : cur.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_rd.head;
    end else if (out_accept && !done) begin
      // data sent, status remains
      cur.has_data <= 1'b0;
    end
  end

endmodule
